// ----- hw/rtl/srws_pkg.sv -----
// shared constants, types and the register length table of the serial register write shifter
// no dependencies
package srws_pkg;

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int HDR_BITS  = 8;
    localparam int NUM_REGS  = 25;
    localparam int MAX_BYTES = DATA_W / 8;
    localparam int MAX_BITS  = HDR_BITS + DATA_W;
    localparam int POS_W     = $clog2(MAX_BITS);
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int TAB_N     = 8;

    typedef logic [CNT_W-1:0] t_byte_cnt;

    // byte counts of the first registers, every later register has four bytes
    localparam t_byte_cnt LEN_TAB [TAB_N] = '{
        t_byte_cnt'(1), t_byte_cnt'(3), t_byte_cnt'(2), t_byte_cnt'(3),
        t_byte_cnt'(4), t_byte_cnt'(2), t_byte_cnt'(3), t_byte_cnt'(2)
    };

    // control from the sequencer to the shift unit
    typedef struct packed {
        logic load;
        logic shift;
    } t_shift_ctrl;

    // status from the shift unit back to the sequencer
    typedef struct packed {
        logic msb;
        logic header;
        logic last;
    } t_shift_stat;

    function automatic t_byte_cnt byte_count(input logic [ADDR_W-1:0] addr);
        t_byte_cnt cnt;
        if (addr < ADDR_W'(TAB_N)) begin
            cnt = LEN_TAB[addr[$clog2(TAB_N)-1:0]];
        end else begin
            cnt = t_byte_cnt'(MAX_BYTES);
        end
        return cnt;
    endfunction

endpackage

// ----- hw/rtl/srws_if.sv -----
// valid/ready channel interfaces of the serial register write shifter
// depends on srws_pkg
interface srws_in_if;
    logic                         valid;
    logic                         ready;
    logic [srws_pkg::ADDR_W-1:0]  reg_addr;
    logic [srws_pkg::DATA_W-1:0]  write_data;
    logic                         apply_update;

    modport source (output valid, output reg_addr, output write_data,
                    output apply_update, input ready);
    modport sink   (input valid, input reg_addr, input write_data,
                    input apply_update, output ready);
endinterface

interface srws_out_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic is_header_bit;
    logic last_bit;
    logic update_pulse;

    modport source (output valid, output serial_bit, output is_header_bit,
                    output last_bit, output update_pulse, input ready);
    modport sink   (input valid, input serial_bit, input is_header_bit,
                    input last_bit, input update_pulse, output ready);
endinterface

// ----- hw/rtl/srws_shift_unit.sv -----
// shared shift register and bit position counter, one bit out per shift
// depends on srws_pkg
module srws_shift_unit (
    input  logic                            i_clk,
    input  srws_pkg::t_shift_ctrl           i_ctrl,
    input  logic [srws_pkg::MAX_BITS-1:0]   i_load_word,
    input  logic [srws_pkg::POS_W-1:0]      i_load_last,
    output srws_pkg::t_shift_stat           o_stat
);
    import srws_pkg::*;

    logic [MAX_BITS-1:0] r_word;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    r_last_pos;

    // load a fresh word or move one bit toward the msb
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_word     <= i_load_word;
            r_pos      <= '0;
            r_last_pos <= i_load_last;
        end else if (i_ctrl.shift) begin
            r_word <= {r_word[MAX_BITS-2:0], 1'b0};
            r_pos  <= r_pos + POS_W'(1);
        end
    end

    // status of the bit now at the msb
    assign o_stat.msb    = r_word[MAX_BITS-1];
    assign o_stat.header = (r_pos < POS_W'(HDR_BITS));
    assign o_stat.last   = (r_pos == r_last_pos);

endmodule

// ----- hw/rtl/serial_register_write_shifter_core.sv -----
// top level of the serial register write shifter: sequencer, load word build, assertions
// depends on srws_pkg, srws_if and srws_shift_unit
//
//  channel | dir | word                                          | handshake
//  i_in    | in  | reg_addr, write_data, apply_update            | valid/ready
//  o_out   | out | serial_bit, is_header_bit, last_bit, update_p | valid/ready
//
// a write to a known register gives 8 + 8 * byte count output words, 16 to 40,
// one per cycle while the sink takes them; the single shift register sets that pace
// a write to an unknown register is dropped in its accept cycle
// i_in is ready only between writes; the next write can be taken the cycle after the last bit
// an output stall holds the current bit; reset returns the sequencer to idle
module serial_register_write_shifter_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    srws_in_if.sink          i_in,
    srws_out_if.source       o_out
);
    import srws_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    t_state              r_state;
    logic                r_upd;
    t_shift_ctrl         shift_ctrl;
    t_shift_stat         shift_stat;
    logic [MAX_BITS-1:0] load_word;
    logic [POS_W-1:0]    load_last;
    logic [DATA_W-1:0]   data_aligned;
    t_byte_cnt           nbytes;
    logic                in_acc;
    logic                out_acc;
    logic                addr_ok;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign addr_ok = ({1'b0, i_in.reg_addr} < (ADDR_W + 1)'(NUM_REGS));
    assign nbytes  = byte_count(i_in.reg_addr);

    // left-justify the sent bytes of the data word
    always_comb begin
        unique case (nbytes)
            t_byte_cnt'(1): data_aligned = {i_in.write_data[7:0], 24'b0};
            t_byte_cnt'(2): data_aligned = {i_in.write_data[15:0], 16'b0};
            t_byte_cnt'(3): data_aligned = {i_in.write_data[23:0], 8'b0};
            default:        data_aligned = i_in.write_data;
        endcase
    end

    assign load_word = {(HDR_BITS)'(i_in.reg_addr), data_aligned};
    assign load_last = POS_W'({nbytes, 3'b111});

    // sequencer drives the shared shift unit
    assign shift_ctrl.load  = in_acc && addr_ok;
    assign shift_ctrl.shift = out_acc;

    srws_shift_unit u_shift (
        .i_clk       (i_clk),
        .i_ctrl      (shift_ctrl),
        .i_load_word (load_word),
        .i_load_last (load_last),
        .o_stat      (shift_stat)
    );

    // state and update request flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_upd   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && addr_ok) begin
                        r_state <= ST_SEND;
                        r_upd   <= i_in.apply_update;
                    end
                end
                ST_SEND: begin
                    if (out_acc && shift_stat.last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // channel outputs
    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = (r_state == ST_SEND);
    assign o_out.serial_bit    = shift_stat.msb;
    assign o_out.is_header_bit = shift_stat.header;
    assign o_out.last_bit      = shift_stat.last;
    assign o_out.update_pulse  = shift_stat.last && r_upd;

    // input and output never both open
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while an output word is pending");

    // taking the last bit frees the input side
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.last_bit) |=> i_in.ready)
        else $error("input not ready after last bit");

    // a known register starts with a header bit
    a_header_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && addr_ok) |=> (o_out.valid && o_out.is_header_bit && !o_out.last_bit))
        else $error("write does not start with a header bit");

    // an unknown register gives no output
    a_drop_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !addr_ok) |=> !o_out.valid)
        else $error("output for an unknown register");

endmodule

// ----- tb/srws_checker.sv -----
`timescale 1ns / 1ps
// checker of the serial register write shifter: watches both channels, builds the bit words
// each accepted write should give and compares them with the words that come out
// depends on srws_pkg
module srws_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [srws_pkg::ADDR_W-1:0] i_in_reg_addr,
    input  logic [srws_pkg::DATA_W-1:0] i_in_write_data,
    input  logic                        i_in_apply_update,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_out_serial_bit,
    input  logic                        i_out_is_header_bit,
    input  logic                        i_out_last_bit,
    input  logic                        i_out_update_pulse,
    output int                          o_pending,
    output int                          o_fail_cnt
);
    import srws_pkg::*;

    // byte counts of registers 0..7, every other known register sends four bytes
    localparam int SHORT_LEN [8] = '{1, 3, 2, 3, 4, 2, 3, 2};

    typedef struct packed {
        logic serial_bit;
        logic is_header_bit;
        logic last_bit;
        logic update_pulse;
    } t_bit_word;

    t_bit_word pending_bits [$];
    int        fail_cnt = 0;
    int        word_idx = 0;

    assign o_pending  = pending_bits.size();
    assign o_fail_cnt = fail_cnt;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch at word %0d: %s", $realtime, word_idx, msg);
        fail_cnt++;
    endtask

    function automatic int write_bytes(input logic [ADDR_W-1:0] addr);
        int n;
        if (addr < 8) begin
            n = SHORT_LEN[addr[2:0]];
        end else begin
            n = 4;
        end
        return n;
    endfunction

    // queue the header bits and the sent data bits of one write, msb first
    task automatic queue_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data,
                               input logic upd);
        int        nbytes;
        int        total;
        logic [7:0] hdr;
        t_bit_word w;
        if (addr >= NUM_REGS) begin
            return;
        end
        nbytes = write_bytes(addr);
        total  = HDR_BITS + 8 * nbytes;
        hdr    = 8'(addr);
        for (int k = 0; k < total; k++) begin
            if (k < HDR_BITS) begin
                w.serial_bit    = hdr[HDR_BITS-1-k];
                w.is_header_bit = 1'b1;
            end else begin
                w.serial_bit    = data[8*nbytes-1-(k-HDR_BITS)];
                w.is_header_bit = 1'b0;
            end
            w.last_bit     = (k == total - 1);
            w.update_pulse = (k == total - 1) ? upd : 1'b0;
            pending_bits.push_back(w);
        end
    endtask

    task automatic check_field(input string name, input logic got, input logic want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %b want %b", name, got, want));
        end
    endtask

    // predict on every accepted write, compare every accepted output word
    always @(posedge i_clk) begin
        t_bit_word want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                queue_write(i_in_reg_addr, i_in_write_data, i_in_apply_update);
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_bits.size() == 0) begin
                    report_mismatch("output word with nothing expected");
                end else begin
                    want = pending_bits.pop_front();
                    check_field("serial_bit", i_out_serial_bit, want.serial_bit);
                    check_field("is_header_bit", i_out_is_header_bit, want.is_header_bit);
                    check_field("last_bit", i_out_last_bit, want.last_bit);
                    check_field("update_pulse", i_out_update_pulse, want.update_pulse);
                end
                word_idx++;
            end
        end
    end

endmodule

// ----- tb/tb_serial_register_write_shifter_core.sv -----
`timescale 1ns / 1ps
// top of the serial register write shifter testbench: clock, reset, write stimulus, random
// output stalls and the verdict; depends on srws_pkg, srws_if, srws_checker and the core
module tb_serial_register_write_shifter_core;
    import srws_pkg::*;

    localparam int RANDOM_WRITES = 270;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 2_000_000;

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   fail_cnt;
    int   cycle_cnt = 0;
    bit   quiet_src = 1'b0;

    srws_in_if  in_ch ();
    srws_out_if out_ch ();

    serial_register_write_shifter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    srws_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (in_ch.valid),
        .i_in_ready          (in_ch.ready),
        .i_in_reg_addr       (in_ch.reg_addr),
        .i_in_write_data     (in_ch.write_data),
        .i_in_apply_update   (in_ch.apply_update),
        .i_out_valid         (out_ch.valid),
        .i_out_ready         (out_ch.ready),
        .i_out_serial_bit    (out_ch.serial_bit),
        .i_out_is_header_bit (out_ch.is_header_bit),
        .i_out_last_bit      (out_ch.last_bit),
        .i_out_update_pulse  (out_ch.update_pulse),
        .o_pending           (pending),
        .o_fail_cnt          (fail_cnt)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT) begin
                $display("tb_serial_register_write_shifter_core NOT OK");
                $finish;
            end
        end
    end

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // output side stalls, with calm stretches in which no new stall starts
    initial begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm_left > 0) begin
                calm_left--;
            end else if ($urandom_range(0, 299) == 0) begin
                calm_left = $urandom_range(50, 200);
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (calm_left == 0 && $urandom_range(0, 99) < 25) begin
                    stall_left = pick_gap() + 1;
                end
            end
        end
    end

    // offer one write after an optional gap, return once it is taken
    task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data,
                              input logic upd);
        int gap;
        gap = quiet_src ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.reg_addr     <= addr;
        in_ch.write_data   <= data;
        in_ch.apply_update <= upd;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // stimulus and verdict
    initial begin
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        int r;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.reg_addr     <= '0;
        in_ch.write_data   <= '0;
        in_ch.apply_update <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every table length, extreme data, unsent upper bytes, unknown registers
        send_write(5'd0,  32'hFFFF_FFFF, 1'b1);
        send_write(5'd0,  32'h0000_0000, 1'b0);
        send_write(5'd1,  32'hA5C3_5A3C, 1'b0);
        send_write(5'd2,  32'h1234_8001, 1'b1);
        send_write(5'd3,  32'h00FF_FFFF, 1'b0);
        send_write(5'd4,  32'hFFFF_FFFF, 1'b1);
        send_write(5'd4,  32'h0000_0000, 1'b0);
        send_write(5'd5,  32'hDEAD_BEEF, 1'b1);
        send_write(5'd6,  32'h8000_0001, 1'b0);
        send_write(5'd7,  32'h7FFF_FFFE, 1'b1);
        send_write(5'd8,  32'h8000_0000, 1'b0);
        send_write(5'd16, 32'h5555_AAAA, 1'b1);
        send_write(5'd24, 32'hFFFF_FFFF, 1'b1);
        send_write(5'd24, 32'h0000_0000, 1'b0);
        send_write(5'd25, 32'hFFFF_FFFF, 1'b1);
        send_write(5'd31, 32'h0000_0000, 1'b1);
        send_write(5'd30, 32'h1357_9BDF, 1'b0);
        send_write(5'd0,  32'h0000_0080, 1'b1);

        // random: mostly known registers, some unknown ones in between
        for (int n = 0; n < RANDOM_WRITES; n++) begin
            if (n % 40 == 0) begin
                quiet_src = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 88) begin
                addr = ADDR_W'($urandom_range(0, NUM_REGS - 1));
            end else begin
                addr = ADDR_W'($urandom_range(NUM_REGS, (1 << ADDR_W) - 1));
            end
            r = $urandom_range(0, 19);
            if (r == 0) begin
                data = '0;
            end else if (r == 1) begin
                data = '1;
            end else begin
                data = $urandom();
            end
            send_write(addr, data, 1'($urandom_range(0, 1)));
        end
        in_ch.valid <= 1'b0;

        // drain
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("tb_serial_register_write_shifter_core OK");
        end else begin
            $display("tb_serial_register_write_shifter_core NOT OK");
        end
        $finish;
    end

endmodule
